[design/swsr_pkg.sv]
// Shared types, codes and reset values for the single-wire sensor reader.
package swsr_pkg;

  // Register reset values
  localparam logic [15:0] START_LOW_RST   = 16'd18000;
  localparam logic [7:0]  RELEASE_RST     = 8'd20;
  localparam logic [7:0]  REPLY_LOW_RST   = 8'd40;
  localparam logic [7:0]  REPLY_HIGH_RST  = 8'd80;
  localparam logic [7:0]  BIT_SAMPLE_RST  = 8'd40;
  localparam logic [15:0] WAIT_TMO_RST    = 16'd9280;   // 1160 * 4 * 2

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_SAMPLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TMO   = 3'd5;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Reply codes
  localparam logic [1:0] REPLY_NONE = 2'd0;
  localparam logic [1:0] REPLY_OK   = 2'd1;
  localparam logic [1:0] REPLY_BAD  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START_LOW  = 4'd1,
    PH_RELEASE    = 4'd2,
    PH_REPLY_LOW  = 4'd3,
    PH_REPLY_HIGH = 4'd4,
    PH_REPLY_FALL = 4'd5,
    PH_BIT_RISE   = 4'd6,
    PH_BIT_SAMPLE = 4'd7,
    PH_BIT_FALL   = 4'd8
  } phase_t;

  typedef struct packed {
    logic [15:0] start_low_us;
    logic [7:0]  release_us;
    logic [7:0]  reply_low_us;
    logic [7:0]  reply_high_us;
    logic [7:0]  bit_sample_us;
    logic [15:0] wait_timeout;
  } cfg_t;

  // Packed so that drive_low lands in bit 0
  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] reply_code;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

endpackage

[design/swsr_cfg.sv]
// Configuration register bank for the single-wire sensor reader.
module swsr_cfg
  import swsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_idx,
  input  logic [15:0]          wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_idx)
        CFG_START_LOW:  cfg_nxt.start_low_us  = wr_data;
        CFG_RELEASE:    cfg_nxt.release_us    = wr_data[7:0];
        CFG_REPLY_LOW:  cfg_nxt.reply_low_us  = wr_data[7:0];
        CFG_REPLY_HIGH: cfg_nxt.reply_high_us = wr_data[7:0];
        CFG_BIT_SAMPLE: cfg_nxt.bit_sample_us = wr_data[7:0];
        CFG_WAIT_TMO:   cfg_nxt.wait_timeout  = wr_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_us  <= START_LOW_RST;
      cfg_r.release_us    <= RELEASE_RST;
      cfg_r.reply_low_us  <= REPLY_LOW_RST;
      cfg_r.reply_high_us <= REPLY_HIGH_RST;
      cfg_r.bit_sample_us <= BIT_SAMPLE_RST;
      cfg_r.wait_timeout  <= WAIT_TMO_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[design/swsr_seq.sv]
// Protocol sequencer: phase, tick counter, bit index and shift byte.
module swsr_seq
  import swsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,      // one tick beat processed this cycle
  input  logic [1:0] command,
  input  logic       pin_level,
  input  cfg_t       cfg,
  output res_t       res        // result after this beat
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [2:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [1:0]  reply_r, reply_nxt;
  logic        done;

  logic [15:0] limit;
  logic        reached;
  logic [15:0] tick_inc;

  // Single compare serves both delays and edge-wait timeouts
  always_comb begin
    unique case (phase_r)
      PH_START_LOW:  limit = cfg.start_low_us;
      PH_RELEASE:    limit = {8'd0, cfg.release_us};
      PH_REPLY_LOW:  limit = {8'd0, cfg.reply_low_us};
      PH_REPLY_HIGH: limit = {8'd0, cfg.reply_high_us};
      PH_BIT_SAMPLE: limit = {8'd0, cfg.bit_sample_us};
      default:       limit = cfg.wait_timeout;
    endcase
  end

  assign reached  = (tick_r >= limit);
  assign tick_inc = tick_r + 16'd1;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (command == CMD_START)     phase_nxt = PH_START_LOW;
        else if (command == CMD_READ) phase_nxt = PH_BIT_RISE;
      end
      PH_START_LOW:  if (reached) phase_nxt = PH_RELEASE;
      PH_RELEASE:    if (reached) phase_nxt = PH_REPLY_LOW;
      PH_REPLY_LOW:  if (reached) phase_nxt = pin_level ? PH_REPLY_FALL : PH_REPLY_HIGH;
      PH_REPLY_HIGH: if (reached) phase_nxt = PH_REPLY_FALL;
      PH_REPLY_FALL: if (reached || !pin_level) phase_nxt = PH_IDLE;
      PH_BIT_RISE:   if (reached || pin_level) phase_nxt = PH_BIT_SAMPLE;
      PH_BIT_SAMPLE: if (reached) phase_nxt = PH_BIT_FALL;
      PH_BIT_FALL: begin
        if (reached || !pin_level)
          phase_nxt = (bit_idx_r == 3'd7) ? PH_IDLE : PH_BIT_RISE;
      end
      default:       phase_nxt = PH_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    reply_nxt   = reply_r;
    done        = 1'b0;
    // counter clears on any phase change, else counts while waiting
    if (phase_nxt != phase_r || phase_r == PH_IDLE) tick_nxt = 16'd0;
    else                                           tick_nxt = tick_inc;
    unique case (phase_r)
      PH_IDLE: begin
        if (command == CMD_READ) bit_idx_nxt = 3'd0;
      end
      PH_REPLY_LOW: begin
        if (reached && pin_level) reply_nxt = REPLY_NONE;
      end
      PH_REPLY_HIGH: begin
        if (reached) reply_nxt = pin_level ? REPLY_OK : REPLY_BAD;
      end
      PH_REPLY_FALL: begin
        if (reached || !pin_level) done = 1'b1;
      end
      PH_BIT_SAMPLE: begin
        if (reached) shift_nxt[~bit_idx_r] = pin_level;
      end
      PH_BIT_FALL: begin
        if (reached || !pin_level) begin
          bit_idx_nxt = bit_idx_r + 3'd1;   // wraps to zero after bit 7
          done        = (bit_idx_r == 3'd7);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.drive_low  = (phase_nxt == PH_START_LOW);
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.done_res   = done;
    res.reply_code = reply_nxt;
    res.data_byte  = shift_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= 16'd0;
      bit_idx_r <= 3'd0;
      shift_r   <= 8'd0;
      reply_r   <= REPLY_NONE;
    end else if (step) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      reply_r   <= reply_nxt;
    end
  end

endmodule

[design/single_wire_sensor_reader.sv]
// Top level of the single-wire humidity sensor reader (host side).
//
//  channel  direction  handshake                 payload
//  in_      slave      in_tvalid / in_tready     in_tdata: command, pin_level
//  out_     master     out_tvalid / out_tready   out_tdata: drive_low .. data_byte
//  cfg_     slave      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One tick beat is taken per cycle while in_tready is high; each beat gives
// exactly one result beat, through the input register, then the result register.
// The sequencer state advances only when a registered beat moves into the
// result register, so its step is the single path between the two registers.
// With out_tready low the result holds, one more beat is parked in the input
// register, then in_tready drops.
// Reset (rst_n, synchronous, active low) empties both registers, puts the
// sequencer in idle and loads the default timings.
// cfg_ready is always high; a write takes effect on the next cycle.
module single_wire_sensor_reader
  import swsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // tick beats
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,    // [1:0] command, [2] pin_level, [7:3] zero
  // result beats
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
                                            // [4:3] reply_code, [12:5] data_byte, [15:13] zero
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t cfg;
  res_t res;

  logic       in_v_r, in_v_nxt;
  logic [1:0] in_cmd_r;
  logic       in_pin_r;
  logic       out_v_r, out_v_nxt;
  res_t       out_res_r;
  logic       advance;
  logic       fire;

  assign cfg_ready = 1'b1;

  swsr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // result register free, or being emptied this cycle
  assign advance   = !out_v_r || out_tready;
  assign fire      = in_v_r && advance;
  assign in_tready = !in_v_r || advance;

  assign in_v_nxt  = in_tready ? in_tvalid : in_v_r;
  assign out_v_nxt = advance ? in_v_r : out_v_r;

  swsr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (fire),
    .command   (in_cmd_r),
    .pin_level (in_pin_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r <= in_tdata[1:0];
      in_pin_r <= in_tdata[2];
    end
    if (fire) out_res_r <= res;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(16 - RES_W){1'b0}}, out_res_r};

endmodule

[tb/sensor_reader_checker.sv]
// Result checker for the sensor reader: tracks the timings, predicts each tick and compares.
`timescale 1ns / 100ps

module sensor_reader_checker
  import swsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [15:0]          out_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   mismatch_count,
  output int                   results_pending,
  output int                   results_checked,
  output int                   sequences_done
);

  localparam int REPORT_LIMIT = 50;

  cfg_t       timing;
  phase_t     seq_phase;
  logic [15:0] seq_count;
  logic [2:0] bit_no;
  logic [7:0] byte_acc;
  logic [1:0] reply_state;

  res_t due_results[$];
  int   mismatches;
  int   checked;
  int   finished;

  function automatic void enter_phase(input phase_t next);
    seq_phase = next;
    seq_count = '0;
  endfunction

  // timed phase: count up to the limit, act on the tick after
  function automatic logic delay_elapsed(input logic [15:0] limit);
    if (seq_count < limit) begin
      seq_count = seq_count + 16'd1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // edge wait: over on the awaited level or once the count reaches the timeout
  function automatic logic wait_ended(input logic seen);
    if (seen || seq_count >= timing.wait_timeout) return 1'b1;
    seq_count = seq_count + 16'd1;
    return 1'b0;
  endfunction

  function automatic res_t sensor_tick(input logic [1:0] cmd, input logic pin);
    res_t r;
    logic fin;
    fin = 1'b0;
    case (seq_phase)
      PH_IDLE: begin
        if (cmd == CMD_START) begin
          enter_phase(PH_START_LOW);
        end else if (cmd == CMD_READ) begin
          bit_no = '0;
          enter_phase(PH_BIT_RISE);
        end
      end
      PH_START_LOW: if (delay_elapsed(timing.start_low_us)) enter_phase(PH_RELEASE);
      PH_RELEASE:   if (delay_elapsed(timing.release_us)) enter_phase(PH_REPLY_LOW);
      PH_REPLY_LOW: begin
        if (delay_elapsed(timing.reply_low_us)) begin
          if (!pin) begin
            enter_phase(PH_REPLY_HIGH);
          end else begin
            reply_state = REPLY_NONE;
            enter_phase(PH_REPLY_FALL);
          end
        end
      end
      PH_REPLY_HIGH: begin
        if (delay_elapsed(timing.reply_high_us)) begin
          reply_state = pin ? REPLY_OK : REPLY_BAD;
          enter_phase(PH_REPLY_FALL);
        end
      end
      PH_REPLY_FALL: begin
        if (wait_ended(!pin)) begin
          enter_phase(PH_IDLE);
          fin = 1'b1;
        end
      end
      PH_BIT_RISE: if (wait_ended(pin)) enter_phase(PH_BIT_SAMPLE);
      PH_BIT_SAMPLE: begin
        if (delay_elapsed(timing.bit_sample_us)) begin
          byte_acc[3'd7 - bit_no] = pin;
          enter_phase(PH_BIT_FALL);
        end
      end
      PH_BIT_FALL: begin
        if (wait_ended(!pin)) begin
          if (bit_no == 3'd7) begin
            bit_no = '0;
            enter_phase(PH_IDLE);
            fin = 1'b1;
          end else begin
            bit_no = bit_no + 3'd1;
            enter_phase(PH_BIT_RISE);
          end
        end
      end
      default: enter_phase(PH_IDLE);
    endcase
    r.drive_low  = (seq_phase == PH_START_LOW);
    r.busy_res   = (seq_phase != PH_IDLE);
    r.done_res   = fin;
    r.reply_code = reply_state;
    r.data_byte  = byte_acc;
    return r;
  endfunction

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      timing.start_low_us  = START_LOW_RST;
      timing.release_us    = RELEASE_RST;
      timing.reply_low_us  = REPLY_LOW_RST;
      timing.reply_high_us = REPLY_HIGH_RST;
      timing.bit_sample_us = BIT_SAMPLE_RST;
      timing.wait_timeout  = WAIT_TMO_RST;
      seq_phase   = PH_IDLE;
      seq_count   = '0;
      bit_no      = '0;
      byte_acc    = '0;
      reply_state = REPLY_NONE;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_LOW:  timing.start_low_us  = cfg_data;
          CFG_RELEASE:    timing.release_us    = cfg_data[7:0];
          CFG_REPLY_LOW:  timing.reply_low_us  = cfg_data[7:0];
          CFG_REPLY_HIGH: timing.reply_high_us = cfg_data[7:0];
          CFG_BIT_SAMPLE: timing.bit_sample_us = cfg_data[7:0];
          CFG_WAIT_TMO:   timing.wait_timeout  = cfg_data;
          default: ;
        endcase
      end
      // a result leaves only after its tick has passed the input and result registers, so retire before predicting
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[RES_W-1:0]);
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result beat with nothing outstanding, expected none, got %h",
                     $time, out_tdata);
        end else begin
          want = due_results.pop_front();
          check_field("drive_low", 32'(want.drive_low), 32'(got.drive_low));
          check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
          check_field("done_res", 32'(want.done_res), 32'(got.done_res));
          check_field("reply_code", 32'(want.reply_code), 32'(got.reply_code));
          check_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
          check_field("tdata padding", 0, 32'(out_tdata[15:RES_W]));
          checked++;
          if (want.done_res) finished++;
        end
      end
      if (in_tvalid && in_tready)
        due_results.push_back(sensor_tick(in_tdata[1:0], in_tdata[2]));
    end
    mismatch_count  <= mismatches;
    results_pending <= due_results.size();
    results_checked <= checked;
    sequences_done  <= finished;
  end

endmodule

[tb/testbench.sv]
// Top of the sensor reader testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module testbench;
  import swsr_pkg::*;

  // code 3 is not defined; the block takes it as a plain tick
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // Longest legal quiet spell is the one long receiver hold (input stalls after two
  // beats); sender gaps are much shorter. Ten times the hold is ample.
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_BEATS = 600;

  typedef enum {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_HEAVY} rx_style_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;    // [1:0] command, [2] pin_level, [7:3] zero
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;          // [0] drive_low, [1] busy_res, [2] done_res,
                                            // [4:3] reply_code, [12:5] data_byte, [15:13] zero
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_START_LOW;
  logic [15:0]          cfg_data   = '0;

  int mismatches;
  int pending;
  int checked;
  int finished;

  // the testbench's own copy of the timings, used only to shape pin waveforms
  cfg_t tim;

  int beats_sent;
  int burst_left;
  bit gaps_on = 1'b1;
  int starts_run;
  int reads_run;
  int forced_tmo;
  int reg_writes;
  int quiet;

  single_wire_sensor_reader dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sensor_reader_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatches),
    .results_pending (pending),
    .results_checked (checked),
    .sequences_done  (finished)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sender side. Beats go out in bursts of random length; between bursts the
  // valid drops for a random gap, unless gaps are switched off for a stretch.
  // Everything is driven with NBAs at the rising edge and the ready is read
  // right after the edge, i.e. the value the DUT saw.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input logic [1:0] cmd, input logic pin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = gaps_on ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, pin, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // tick while a sequence runs; now and then a stray command, which must be ignored
  task automatic busy_tick(input logic pin);
    logic [1:0] c;
    c = CMD_TICK;
    if ($urandom_range(0, 7) == 0) c = 2'($urandom_range(1, 3));
    send_tick(c, pin);
  endtask

  // a few idle ticks, plain or with the undefined code
  task automatic idle_ticks();
    int n;
    n = $urandom_range(0, 3);
    repeat (n) send_tick(($urandom_range(0, 1) != 0) ? CMD_SPARE : CMD_TICK,
                         1'($urandom_range(0, 1)));
  endtask

  // timed phase: limit ticks in which the pin is not looked at, then the acting tick
  task automatic hold_for(input int unsigned limit, input logic last_pin);
    repeat (limit) busy_tick(1'($urandom_range(0, 1)));
    busy_tick(last_pin);
  endtask

  // edge wait: 'lead' ticks at the wrong level, then the awaited level - or, if the
  // lead is past the timeout, exactly enough wrong ticks for the wait to give up
  task automatic await_level(input logic level, input int unsigned lead);
    int unsigned n;
    n = 32'(tim.wait_timeout);
    if (lead > n) begin
      forced_tmo++;
      repeat (n + 1) busy_tick(~level);
    end else begin
      repeat (lead) busy_tick(~level);
      busy_tick(level);
    end
  endtask

  // random timeouts only where the timeout is short, else the run gets long
  function automatic int unsigned pick_lead(input bit force_tmo);
    int unsigned n;
    n = 32'(tim.wait_timeout);
    if (force_tmo) return n + 1;
    if (n <= 64 && $urandom_range(0, 9) == 0) return n + 1;
    return $urandom_range(0, 4);
  endfunction

  // start: hold low, release, then the sensor's low and high replies as asked
  task automatic run_start(input logic [1:0] outcome, input bit force_tmo);
    starts_run++;
    send_tick(CMD_START, 1'($urandom_range(0, 1)));
    hold_for(32'(tim.start_low_us), 1'($urandom_range(0, 1)));
    hold_for(32'(tim.release_us), 1'($urandom_range(0, 1)));
    hold_for(32'(tim.reply_low_us), outcome == REPLY_NONE);   // pin high means no low reply
    if (outcome != REPLY_NONE) hold_for(32'(tim.reply_high_us), outcome == REPLY_OK);
    await_level(1'b0, pick_lead(force_tmo));
  endtask

  // read: eight bits, MSB first, each rise / sample / fall
  task automatic run_read(input logic [7:0] value, input bit force_tmo);
    reads_run++;
    send_tick(CMD_READ, 1'($urandom_range(0, 1)));
    for (int i = 7; i >= 0; i--) begin
      await_level(1'b1, pick_lead(force_tmo));
      hold_for(32'(tim.bit_sample_us), value[i]);
      await_level(1'b0, pick_lead(force_tmo));
    end
  endtask

  task automatic random_sequence();
    int k;
    k = $urandom_range(0, 9);
    idle_ticks();
    if (k < 5)      run_read(8'($urandom), 1'b0);
    else if (k < 7) run_start(REPLY_OK, 1'b0);
    else if (k < 9) run_start(REPLY_BAD, 1'b0);
    else            run_start(REPLY_NONE, 1'b0);
  endtask

  // wait until every result is in, then let the two-stage pipe settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  // all six registers, only ever with the block idle
  task automatic set_timing(input cfg_t t);
    drain_results();
    write_reg(CFG_START_LOW, t.start_low_us);
    write_reg(CFG_RELEASE, {8'd0, t.release_us});
    write_reg(CFG_REPLY_LOW, {8'd0, t.reply_low_us});
    write_reg(CFG_REPLY_HIGH, {8'd0, t.reply_high_us});
    write_reg(CFG_BIT_SAMPLE, {8'd0, t.bit_sample_us});
    write_reg(CFG_WAIT_TMO, t.wait_timeout);
    cfg_valid <= 1'b0;
    tim = t;
  endtask

  function automatic cfg_t timing(input logic [15:0] start_low, input logic [7:0] rel,
                                  input logic [7:0] rlow, input logic [7:0] rhigh,
                                  input logic [7:0] bsample, input logic [15:0] tmo);
    cfg_t t;
    t.start_low_us  = start_low;
    t.release_us    = rel;
    t.reply_low_us  = rlow;
    t.reply_high_us = rhigh;
    t.bit_sample_us = bsample;
    t.wait_timeout  = tmo;
    return t;
  endfunction

  // mostly very short delays so that many sequences fit, now and then longer ones
  function automatic int unsigned pick_delay();
    if ($urandom_range(0, 7) == 0) return $urandom_range(7, 40);
    return $urandom_range(0, 6);
  endfunction

  function automatic cfg_t random_timing();
    return timing(16'(pick_delay()), 8'(pick_delay()), 8'(pick_delay()), 8'(pick_delay()),
                  8'(pick_delay()), 16'($urandom_range(0, 12)));
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int base;
    tim = timing(START_LOW_RST, RELEASE_RST, REPLY_LOW_RST, REPLY_HIGH_RST,
                 BIT_SAMPLE_RST, WAIT_TMO_RST);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset timings: a read with no start before it
    run_read(8'hA5, 1'b0);

    // every delay and the timeout at zero
    set_timing(timing(16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0));
    run_start(REPLY_OK, 1'b0);
    run_start(REPLY_BAD, 1'b0);
    run_start(REPLY_NONE, 1'b0);
    run_read(8'hFF, 1'b0);
    run_read(8'h00, 1'b0);
    idle_ticks();

    // short fixed timings; missing reply, malformed reply, and a read with every edge wait timing out
    set_timing(timing(16'd3, 8'd2, 8'd4, 8'd3, 8'd2, 16'd6));
    run_start(REPLY_NONE, 1'b1);
    run_start(REPLY_BAD, 1'b0);
    run_read(8'h5A, 1'b1);

    // top of the 8-bit delay range and the largest timeout; no sender gaps here
    gaps_on = 1'b0;
    set_timing(timing(16'd2, 8'hFF, 8'd3, 8'd2, 8'd1, 16'hFFFF));
    run_start(REPLY_OK, 1'b0);

    // random timings, a handful of sequences under each
    base = beats_sent;
    while (beats_sent - base < RANDOM_BEATS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      set_timing(random_timing());
      repeat ($urandom_range(1, 4)) random_sequence();
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Run covered %0d tick beats: %0d starts, %0d reads, %0d edge waits timed out,",
             beats_sent, starts_run, reads_run, forced_tmo);
    $display("  %0d register writes, %0d results checked, %0d sequences finished.",
             reg_writes, checked, finished);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: its own stall pattern, changing style at random, plus one
  // long hold-off once results are flowing so that the input register fills
  // and in_tready drops while beats are still on offer.
  // ---------------------------------------------------------------------------
  initial begin
    rx_style_t style;
    int left;
    int cyc;
    bit held;
    style = RX_OPEN;
    left  = 0;
    cyc   = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && checked >= 50) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (left == 0) begin
        style = rx_style_t'($urandom_range(0, 3));
        left  = $urandom_range(32, 256);
      end
      left--;
      cyc++;
      case (style)
        RX_OPEN:     out_tready <= 1'b1;
        RX_SPARSE:   out_tready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_tready <= ((cyc % 5) != 0);
        default:     out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // watchdog: too long without any beat moving on any channel ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet + 1);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule

[single_wire_sensor_reader.f]
design/swsr_pkg.sv
design/swsr_cfg.sv
design/swsr_seq.sv
design/single_wire_sensor_reader.sv
tb/sensor_reader_checker.sv
tb/testbench.sv
